>>> design/fdcd_pkg.sv
// Shared types, frame constants and the glyph segment table for the frame decoder.
package fdcd_pkg;

   localparam int DIGIT_COUNT = 5;
   localparam int CODE_WIDTH  = 7;
   localparam int SEG_WIDTH   = 8;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] SYNC_BYTE = 8'hff;
   localparam logic [7:0] ZERO_BYTE = 8'h00;

   // Frame positions: header bytes, glyph codes and the trailer.
   localparam logic [3:0] POS_HEAD0   = 4'd0;
   localparam logic [3:0] POS_HEAD1   = 4'd1;
   localparam logic [3:0] POS_HEAD2   = 4'd2;
   localparam logic [3:0] POS_HEAD3   = 4'd3;
   localparam logic [3:0] POS_GLYPH0  = 4'd4;
   localparam logic [3:0] POS_GLYPH1  = 4'd5;
   localparam logic [3:0] POS_GLYPH2  = 4'd6;
   localparam logic [3:0] POS_GLYPH3  = 4'd7;
   localparam logic [3:0] POS_GLYPH4  = 4'd8;
   localparam logic [3:0] POS_TRAILER = 4'd9;

   // Five glyph codes of one completed frame.
   typedef logic [DIGIT_COUNT-1:0][CODE_WIDTH-1:0] glyph_set_type;

   // Active-low segment patterns; the upper half carries the bottom triangle lit.
   localparam logic [SEG_WIDTH-1:0] GLYPH_ROM [64] = '{
      8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8, 8'h80, 8'h90,
      8'h88, 8'h83, 8'hc6, 8'ha7, 8'ha1, 8'h86, 8'h8e, 8'h8b, 8'hf1, 8'hc7,
      8'hab, 8'ha3, 8'h8c, 8'h98, 8'haf, 8'he3, 8'h91, 8'h3f, 8'h3f, 8'h3f,
      8'h3f, 8'h3f,
      8'h40, 8'h79, 8'h24, 8'h30, 8'h19, 8'h12, 8'h02, 8'h78, 8'h00, 8'h10,
      8'h08, 8'h03, 8'h46, 8'h27, 8'h21, 8'h06, 8'h0e, 8'h0b, 8'h71, 8'h47,
      8'h2b, 8'h23, 8'h0c, 8'h18, 8'h2f, 8'h63, 8'h11, 8'h3f, 8'h3f, 8'h3f,
      8'h3f, 8'h3f
   };

endpackage

>>> design/fdcd_front.sv
// Front end: tracks the frame position, checks glyph codes and hands off complete frames.
module fdcd_front import fdcd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [7:0]    req_rx_byte,
   output logic          push_valid,
   input  logic          push_ready,
   output glyph_set_type push_codes
);

   logic [3:0]    pos_ff, pos_in;
   glyph_set_type codes_ff, codes_in;
   logic          code_ok;
   logic          trailer_hit;
   logic          take;

   // A glyph code must fall in one of the four allowed ranges.
   always_comb begin
      code_ok = (req_rx_byte <= 8'h1c) ||
                (req_rx_byte >= 8'h20 && req_rx_byte <= 8'h3a) ||
                (req_rx_byte >= 8'h40 && req_rx_byte <= 8'h5a) ||
                (req_rx_byte >= 8'h60 && req_rx_byte <= 8'h7a);
   end

   // The front only stalls when a finished frame cannot enter the queue.
   assign trailer_hit = (pos_ff == POS_TRAILER) && (req_rx_byte == SYNC_BYTE);
   assign req_ready   = !trailer_hit || push_ready;
   assign take        = req_valid && req_ready;
   assign push_valid  = req_valid && trailer_hit;
   assign push_codes  = codes_ff;

   // Next position and glyph capture for the accepted byte.
   always_comb begin
      pos_in   = pos_ff;
      codes_in = codes_ff;
      if (take) begin
         unique case (pos_ff)
            POS_HEAD1, POS_HEAD2: begin
               if (req_rx_byte == ZERO_BYTE) begin
                  pos_in = pos_ff + 4'd1;
               end else if (req_rx_byte == SYNC_BYTE) begin
                  pos_in = POS_HEAD1;
               end else begin
                  pos_in = POS_HEAD0;
               end
            end
            POS_HEAD3: begin
               pos_in = (req_rx_byte == SYNC_BYTE) ? POS_GLYPH0 : POS_HEAD0;
            end
            POS_GLYPH0, POS_GLYPH1, POS_GLYPH2, POS_GLYPH3, POS_GLYPH4: begin
               if (code_ok) begin
                  codes_in[3'(pos_ff - POS_GLYPH0)] = req_rx_byte[CODE_WIDTH-1:0];
                  pos_in = pos_ff + 4'd1;
               end else if (req_rx_byte == SYNC_BYTE) begin
                  pos_in = POS_HEAD1;
               end else begin
                  pos_in = POS_HEAD0;
               end
            end
            POS_TRAILER: begin
               pos_in = POS_HEAD0;
            end
            default: begin
               // Header start, and any unreachable position, hunt for the first sync byte.
               pos_in = (req_rx_byte == SYNC_BYTE) ? POS_HEAD1 : POS_HEAD0;
            end
         endcase
      end
   end

   // Position register is control state; the stored codes are payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_HEAD0;
      end else begin
         pos_ff <= pos_in;
      end
      codes_ff <= codes_in;
   end

endmodule

>>> design/fdcd_queue.sv
// Short queue of completed frames between the front and back ends.
module fdcd_queue import fdcd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  glyph_set_type push_codes,
   output logic          pop_valid,
   input  logic          pop_ready,
   output glyph_set_type pop_codes
);

   localparam int PTR_WIDTH = $clog2(QUEUE_DEPTH);

   glyph_set_type         entries_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_WIDTH:0]    count_ff, count_in;
   logic                  do_push, do_pop;

   assign push_ready = (count_ff != (PTR_WIDTH+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_codes  = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and occupancy updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_codes;
      end
   end

endmodule

>>> design/fdcd_back.sv
// Back end: looks up segment patterns for a frame and holds the result register.
module fdcd_back import fdcd_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  glyph_set_type                 pop_codes,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [DIGIT_COUNT-1:0][SEG_WIDTH-1:0] rsp_segs,
   output logic [DIGIT_COUNT-1:0]        rsp_top_off
);

   logic                                  valid_ff, valid_in;
   logic [DIGIT_COUNT-1:0][SEG_WIDTH-1:0] segs_ff, segs_in;
   logic [DIGIT_COUNT-1:0]                top_off_ff, top_off_in;
   logic                                  load;

   // The result register accepts a new frame whenever it is empty or being drained.
   assign pop_ready = !valid_ff || rsp_ready;
   assign load      = pop_valid && pop_ready;

   // Codes below 0x40 index the table directly with the top triangle off;
   // higher codes drop bit 6, which is the same as subtracting 0x40.
   always_comb begin
      for (int k = 0; k < DIGIT_COUNT; k++) begin
         segs_in[k]    = GLYPH_ROM[pop_codes[k][5:0]];
         top_off_in[k] = !pop_codes[k][6];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         segs_ff    <= segs_in;
         top_off_ff <= top_off_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_segs    = segs_ff;
   assign rsp_top_off = top_off_ff;

endmodule

>>> design/framed_digit_command_decoder.sv
// Top level of the framed digit command decoder: front end, frame queue and back end.
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_ready   req_rx_byte
//   rsp       out        rsp_valid/rsp_ready   rsp_seg_digit0..4, rsp_top_off0..4
//
// One byte is taken every cycle while req_ready is high.
// A completed frame passes through a two-entry queue and is then loaded into the
// result register, given room downstream.
// Reset clears the frame position, the queue and the result valid flag.
// The request side stalls only when the queue is full at a trailer byte.
module framed_digit_command_decoder import fdcd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_seg_digit0,
   output logic [7:0] rsp_seg_digit1,
   output logic [7:0] rsp_seg_digit2,
   output logic [7:0] rsp_seg_digit3,
   output logic [7:0] rsp_seg_digit4,
   output logic       rsp_top_off0,
   output logic       rsp_top_off1,
   output logic       rsp_top_off2,
   output logic       rsp_top_off3,
   output logic       rsp_top_off4
);

   logic                                  push_valid, push_ready;
   glyph_set_type                         push_codes;
   logic                                  pop_valid, pop_ready;
   glyph_set_type                         pop_codes;
   logic [DIGIT_COUNT-1:0][SEG_WIDTH-1:0] segs;
   logic [DIGIT_COUNT-1:0]                top_off;

   fdcd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_codes  (push_codes)
   );

   fdcd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_codes (push_codes),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_codes  (pop_codes)
   );

   fdcd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_codes   (pop_codes),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_segs    (segs),
      .rsp_top_off (top_off)
   );

   // Fan the packed result out to one port per digit.
   assign rsp_seg_digit0 = segs[0];
   assign rsp_seg_digit1 = segs[1];
   assign rsp_seg_digit2 = segs[2];
   assign rsp_seg_digit3 = segs[3];
   assign rsp_seg_digit4 = segs[4];
   assign rsp_top_off0   = top_off[0];
   assign rsp_top_off1   = top_off[1];
   assign rsp_top_off2   = top_off[2];
   assign rsp_top_off3   = top_off[3];
   assign rsp_top_off4   = top_off[4];

endmodule
